@@ rtl/gmtk_pkg.sv @@
// Shared constants, types and helpers for the grid match top-k selector.
// Used by every module in this folder; depends on nothing else.
package gmtk_pkg;

	localparam int MAX_TILES      = 256;
	localparam int TOP_K          = 10;
	localparam int MAX_CANDIDATES = 1023;

	localparam int DIM_W   = 5;
	localparam int TILE_W  = 8;
	localparam int MODE_W  = 2;
	localparam int POS_W   = $clog2(MAX_TILES);
	localparam int SIZE_W  = $clog2(MAX_TILES + 1);
	localparam int SCORE_W = 9;
	localparam int NUM_W   = 10;
	localparam int SLOT_W  = 4;
	localparam int IDX_W   = $clog2(TOP_K);
	localparam int FILL_W  = $clog2(TOP_K + 1);
	localparam int ODATA_W = 24;

	localparam logic [MODE_W-1:0] MODE_REF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CAND   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [DIM_W-1:0] DIM_MIN   = 5'd1;
	localparam logic [DIM_W-1:0] DIM_MAX   = 5'd16;
	localparam logic [DIM_W-1:0] DIM_RESET = 5'd4;

	// A finished candidate handed from the scoring side to the ranking side.
	typedef struct packed {
		logic               valid;
		logic [SCORE_W-1:0] score;
	} close_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_MIN) r = DIM_MIN;
		if (v > DIM_MAX) r = DIM_MAX;
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] grid_size(input logic [DIM_W-1:0] rows,
			input logic [DIM_W-1:0] cols);
		logic [2*DIM_W-1:0] prod;
		prod = clamp_dim(rows) * clamp_dim(cols);
		if (prod > (2*DIM_W)'(MAX_TILES)) prod = (2*DIM_W)'(MAX_TILES);
		return SIZE_W'(prod);
	endfunction

endpackage

@@ rtl/gmtk_score.sv @@
// Reference tile memory and candidate scoring: loads the reference grid and
// compares candidate tiles against it. Depends on gmtk_pkg.
module gmtk_score import gmtk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               beat_valid,
	input  logic [MODE_W-1:0]  mode,
	input  logic [TILE_W-1:0]  tile,
	input  logic [SIZE_W-1:0]  size,
	output logic               busy,
	output close_t             close
);

	logic [TILE_W-1:0] ref_mem [MAX_TILES];
	logic [TILE_W-1:0] rd_data_s1;
	logic [TILE_W-1:0] tile_s1;
	logic              cmp_s1;
	logic [POS_W-1:0]  ref_pos_q;
	logic [POS_W-1:0]  cand_pos_q;
	logic [SCORE_W-1:0] score_q;

	logic               ref_we;
	logic               cand_re;
	logic               ref_wrap;
	logic               cand_last;
	logic [SCORE_W-1:0] new_score;

	assign ref_we    = beat_valid && (mode == MODE_REF);
	assign cand_re   = beat_valid && (mode == MODE_CAND);
	assign ref_wrap  = ({1'b0, ref_pos_q} + SIZE_W'(1)) >= size;
	assign cand_last = ({1'b0, cand_pos_q} + SIZE_W'(1)) >= size;
	assign new_score = score_q + SCORE_W'(rd_data_s1 == tile_s1);

	assign busy        = cmp_s1;
	assign close.valid = cmp_s1 && cand_last;
	assign close.score = new_score;

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_pos_q] <= tile;
		end
		if (cand_re) begin
			rd_data_s1 <= ref_mem[cand_pos_q];
			tile_s1    <= tile;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1     <= 1'b0;
			ref_pos_q  <= '0;
			cand_pos_q <= '0;
			score_q    <= '0;
		end else begin
			cmp_s1 <= cand_re;
			if (ref_we) begin
				ref_pos_q <= ref_wrap ? '0 : ref_pos_q + POS_W'(1);
			end
			// The compare runs the cycle after the read; the grid closes on its last tile.
			if (cmp_s1) begin
				if (cand_last) begin
					cand_pos_q <= '0;
					score_q    <= '0;
				end else begin
					cand_pos_q <= cand_pos_q + POS_W'(1);
					score_q    <= new_score;
				end
			end
		end
	end

	a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_s1 |=> !cmp_s1) else $error("compare stage held for more than one cycle");
	a_no_beat_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_s1 |-> !beat_valid) else $error("beat accepted while a compare is pending");

endmodule

@@ rtl/gmtk_rank.sv @@
// Top-k list memory with the minimum scan, replacement and report readout.
// Depends on gmtk_pkg.
module gmtk_rank import gmtk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  close_t             close,
	input  logic               rep_start,
	output logic               busy,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,  // rank_slot[3:0], candidate_number[13:4], match_score[22:14]
	output logic               m_tuser,  // entry_valid
	output logic               m_tlast
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_REP_RD = 3'd4;
	localparam logic [2:0] ST_REP_LD = 3'd5;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_K - 1);

	logic [NUM_W+SCORE_W-1:0] kept_mem [TOP_K];

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    slot_q;
	logic [FILL_W-1:0]   filled_q;
	logic [NUM_W-1:0]    cnt_q;
	logic [SCORE_W-1:0]  off_score_q;
	logic [NUM_W-1:0]    off_num_q;
	logic [SCORE_W-1:0]  min_score_q;
	logic [IDX_W-1:0]    min_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [NUM_W-1:0]    rd_num_s1;
	logic [SCORE_W-1:0]  rd_score_s1;

	logic                m_tvalid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_valid_q;
	logic [NUM_W-1:0]    out_num_q;
	logic [SCORE_W-1:0]  out_score_q;
	logic                out_last_q;

	logic                re;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [NUM_W-1:0]    wnum;
	logic [SCORE_W-1:0]  wscore;
	logic [NUM_W-1:0]    next_num;
	logic                list_full;
	logic                out_free;
	logic                slot_valid;

	assign next_num   = (cnt_q < NUM_W'(MAX_CANDIDATES)) ? cnt_q + NUM_W'(1) : cnt_q;
	assign list_full  = filled_q >= FILL_W'(TOP_K);
	assign out_free   = !m_tvalid_q || m_tready;
	assign slot_valid = FILL_W'(slot_q) < filled_q;
	assign re         = (state_q == ST_SCAN) || (state_q == ST_REP_RD);
	assign busy       = state_q != ST_IDLE;

	always_comb begin
		we     = 1'b0;
		waddr  = slot_q;
		wnum   = off_num_q;
		wscore = off_score_q;
		unique case (state_q)
			ST_IDLE: begin
				// While the list is filling, a closed candidate takes the next slot.
				if (close.valid && !list_full) begin
					we     = 1'b1;
					waddr  = IDX_W'(filled_q);
					wnum   = next_num;
					wscore = close.score;
				end
			end
			ST_DECIDE: begin
				if (off_score_q > min_score_q) begin
					we    = 1'b1;
					waddr = min_idx_q;
				end
			end
			ST_SCAN, ST_DRAIN, ST_REP_RD, ST_REP_LD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			kept_mem[waddr] <= {wnum, wscore};
		end
		if (re) begin
			{rd_num_s1, rd_score_s1} <= kept_mem[slot_q];
			rd_idx_s1 <= slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			filled_q    <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= state_q == ST_SCAN;
			if ((state_q == ST_REP_LD) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (close.valid) begin
						cnt_q <= next_num;
						if (!list_full) begin
							filled_q <= filled_q + FILL_W'(1);
						end else begin
							slot_q  <= '0;
							state_q <= ST_SCAN;
						end
					end else if (rep_start) begin
						slot_q  <= '0;
						state_q <= ST_REP_RD;
					end
				end
				ST_SCAN: begin
					if (slot_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						slot_q <= slot_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
				end
				ST_REP_RD: begin
					state_q <= ST_REP_LD;
				end
				ST_REP_LD: begin
					if (out_free) begin
						if (slot_q == LAST_IDX) begin
							filled_q <= '0;
							cnt_q    <= '0;
							state_q  <= ST_IDLE;
						end else begin
							slot_q  <= slot_q + IDX_W'(1);
							state_q <= ST_REP_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Running minimum over the scan; the earliest slot wins a tie.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			off_num_q   <= next_num;
			off_score_q <= close.score;
		end
		if (rd_vld_s1 && ((rd_idx_s1 == '0) || (rd_score_s1 < min_score_q))) begin
			min_score_q <= rd_score_s1;
			min_idx_q   <= rd_idx_s1;
		end
		if ((state_q == ST_REP_LD) && out_free) begin
			out_slot_q  <= SLOT_W'(slot_q);
			out_valid_q <= slot_valid;
			out_num_q   <= slot_valid ? rd_num_s1 : '0;
			out_score_q <= slot_valid ? rd_score_s1 : '0;
			out_last_q  <= slot_q == LAST_IDX;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(ODATA_W - SLOT_W - NUM_W - SCORE_W)'(0), out_score_q, out_num_q,
		out_slot_q};
	assign m_tuser  = out_valid_q;
	assign m_tlast  = out_last_q;

	a_close_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		close.valid |-> (state_q == ST_IDLE)) else $error("candidate closed while list busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(TOP_K)) else $error("fill count past list size");
	a_scan_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SCAN)) else $error("scan data without scan read");

endmodule

@@ rtl/grid_match_top_k_selector.sv @@
// Grid match top-k selector, top level: configuration registers, input beat
// decode and the scoring and ranking units. Depends on gmtk_pkg, gmtk_score, gmtk_rank.
//
// A reference-load beat (tuser 0) is written into the reference memory. A
// candidate beat (tuser 1) has two steps: the reference memory is read, then
// the tile is compared. On the last tile of a candidate the new entry is
// written during the compare while the list is filling; once all ten slots
// are held, the ranking unit scans: the list memory is read one slot per
// cycle, a drain state lets the last read land, and a decide state decides
// and writes. A report beat (tuser 2) produces ten result beats in slot
// order, each from a read state and a load state that waits out any output
// stall, and the list is empty afterwards. Input is not accepted while either
// unit is busy. Writes to the grid size take effect on the next beat.
module grid_match_top_k_selector import gmtk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TILE_W-1:0]  s_tdata,   // tile[7:0]
	input  logic [MODE_W-1:0]  s_tuser,   // mode[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,   // rank_slot[3:0], candidate_number[13:4],
	                                      // match_score[22:14], zero fill above
	output logic               m_tuser,   // entry_valid
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [DIM_W-1:0]   cfg_wdata
);

	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  cols_q;
	logic [SIZE_W-1:0] size;
	logic              accept;
	logic              score_busy;
	logic              rank_busy;
	close_t            close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_wdata;
				REG_COLS: cols_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign size     = grid_size(rows_q, cols_q);
	assign s_tready = !score_busy && !rank_busy;
	assign accept   = s_tvalid && s_tready;

	gmtk_score u_score (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (accept),
		.mode       (s_tuser),
		.tile       (s_tdata),
		.size       (size),
		.busy       (score_busy),
		.close      (close)
	);

	gmtk_rank u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.close     (close),
		.rep_start (accept && (s_tuser == MODE_REPORT)),
		.busy      (rank_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
